/* design/mcom_pkg.sv */
// Package for the masked center-of-mass block.
// Holds field and accumulator widths, the sequencer state type.
// No dependencies.
package mcom_pkg;

  // Largest selected-atom count the accumulators hold without wrapping
  localparam int unsigned MAX_ATOMS = 4096;
  localparam int unsigned GROW_W    = $clog2(MAX_ATOMS);

  localparam int unsigned MASS_IN_W = 16;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned PROD_W    = MASS_IN_W + POS_W + 1;
  localparam int unsigned MASS_W    = MASS_IN_W + GROW_W;
  localparam int unsigned MOM_W     = MASS_IN_W + POS_W + GROW_W;
  localparam int unsigned CNT_W     = $clog2(MOM_W);
  localparam int unsigned AXES      = 3;
  localparam int unsigned AXIS_W    = $clog2(AXES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WAIT,
    ST_LOAD,
    ST_DIV,
    ST_SAT
  } state_e;

endpackage

/* design/masked_center_of_mass.sv */
// An unselected atom needs no datapath work; a selected atom makes three
// multiply/accumulate passes through one shared 17x32 multiplier.
// After the last atom of a set, once the previous result is taken, one shared
// restoring divider produces one quotient bit per cycle for each axis.
// A new atom is taken only when the block is idle; in_ready_o is low while busy.
// Reset (async, active low) clears the accumulators and drops out_valid_o.
module masked_center_of_mass
  import mcom_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_qm_i,
  input  logic                    in_boundary_i,
  input  logic [MASS_IN_W-1:0]    mass_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic                    is_last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [POS_W-1:0] center_x_o,
  output logic signed [POS_W-1:0] center_y_o,
  output logic signed [POS_W-1:0] center_z_o,
  output logic                    no_mass_o
);

  state_e                   state_q, state_d;
  logic [AXIS_W-1:0]        axis_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     last_q;
  logic                     out_valid_q;
  logic                     no_mass_q;
  logic [MASS_W-1:0]        mass_total_q;
  logic [MOM_W-1:0]         mom_q [AXES];

  logic [MASS_IN_W-1:0]     mass_q;
  logic signed [POS_W-1:0]  pos_q [AXES];
  logic signed [PROD_W-1:0] prod_q;
  logic [MOM_W-1:0]         dq_q;
  logic [MASS_W-1:0]        rem_q;
  logic                     neg_q;
  logic signed [POS_W-1:0]  center_q [AXES];

  logic                     in_fire;
  logic                     sel;
  logic signed [PROD_W-1:0] prod_d;
  logic [MOM_W-1:0]         mom_sel;
  logic [MOM_W-1:0]         mag;
  logic [MASS_W:0]          trial;
  logic                     q_bit;
  logic [MASS_W-1:0]        rem_d;
  logic                     ovf_pos, ovf_neg;
  logic [POS_W-1:0]         sat_val;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign sel        = in_qm_i || in_boundary_i;

  // shared multiplier: mass (as positive signed) times one coordinate
  assign prod_d  = $signed({1'b0, mass_q}) * pos_q[axis_q];

  // magnitude of the moment for the divider
  assign mom_sel = mom_q[axis_q];
  assign mag     = mom_sel[MOM_W-1] ? (~mom_sel + MOM_W'(1)) : mom_sel;

  // one restoring-division step
  assign trial = {rem_q, dq_q[MOM_W-1]};
  assign q_bit = (trial >= {1'b0, mass_total_q});
  assign rem_d = q_bit ? MASS_W'(trial - {1'b0, mass_total_q}) : MASS_W'(trial);

  // saturate the signed quotient to 32 bits
  assign ovf_pos = |dq_q[MOM_W-1:POS_W-1];
  assign ovf_neg = (|dq_q[MOM_W-1:POS_W]) || (dq_q[POS_W-1] && (|dq_q[POS_W-2:0]));
  always_comb begin
    if (neg_q) begin
      sat_val = ovf_neg ? {1'b1, {(POS_W-1){1'b0}}} : (POS_W'(0) - dq_q[POS_W-1:0]);
    end else begin
      sat_val = ovf_pos ? {1'b0, {(POS_W-1){1'b1}}} : dq_q[POS_W-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (sel)            state_d = ST_MUL;
          else if (is_last_i) state_d = ST_WAIT;
        end
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: begin
        if (axis_q != AXIS_W'(AXES-1)) state_d = ST_MUL;
        else if (last_q)               state_d = ST_WAIT;
        else                           state_d = ST_IDLE;
      end
      ST_WAIT: begin
        if (!out_valid_q) begin
          state_d = (mass_total_q == '0) ? ST_IDLE : ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_SAT;
      end
      ST_SAT: begin
        state_d = (axis_q == AXIS_W'(AXES-1)) ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      axis_q       <= '0;
      cnt_q        <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      no_mass_q    <= 1'b0;
      mass_total_q <= '0;
      for (int i = 0; i < AXES; i++) mom_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            last_q <= is_last_i;
            axis_q <= '0;
            if (sel) mass_total_q <= mass_total_q + MASS_W'(mass_i);
          end
        end
        ST_ADD: begin
          mom_q[axis_q] <= mom_q[axis_q] + MOM_W'(prod_q);
          axis_q <= (axis_q == AXIS_W'(AXES-1)) ? '0 : axis_q + AXIS_W'(1);
        end
        ST_WAIT: begin
          if (!out_valid_q) begin
            axis_q <= '0;
            if (mass_total_q == '0) begin
              out_valid_q <= 1'b1;
              no_mass_q   <= 1'b1;
              for (int i = 0; i < AXES; i++) mom_q[i] <= '0;
            end
          end
        end
        ST_LOAD: cnt_q <= CNT_W'(MOM_W-1);
        ST_DIV:  cnt_q <= cnt_q - CNT_W'(1);
        ST_SAT: begin
          if (axis_q == AXIS_W'(AXES-1)) begin
            axis_q       <= '0;
            out_valid_q  <= 1'b1;
            no_mass_q    <= 1'b0;
            mass_total_q <= '0;
            for (int i = 0; i < AXES; i++) mom_q[i] <= '0;
          end else begin
            axis_q <= axis_q + AXIS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mass_q   <= mass_i;
          pos_q[0] <= pos_x_i;
          pos_q[1] <= pos_y_i;
          pos_q[2] <= pos_z_i;
        end
      end
      ST_MUL: prod_q <= prod_d;
      ST_WAIT: begin
        if (!out_valid_q && (mass_total_q == '0)) begin
          for (int i = 0; i < AXES; i++) center_q[i] <= '0;
        end
      end
      ST_LOAD: begin
        neg_q <= mom_sel[MOM_W-1];
        dq_q  <= mag;
        rem_q <= '0;
      end
      ST_DIV: begin
        dq_q  <= {dq_q[MOM_W-2:0], q_bit};
        rem_q <= rem_d;
      end
      ST_SAT: center_q[axis_q] <= sat_val;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign no_mass_o   = no_mass_q;
  assign center_x_o  = center_q[0];
  assign center_y_o  = center_q[1];
  assign center_z_o  = center_q[2];

endmodule

/* design/mcom_checker.sv */
// Port-level checks for the masked center-of-mass block, bound to the top.
// Depends on mcom_pkg and masked_center_of_mass.
module mcom_props
  import mcom_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    is_last_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [POS_W-1:0] center_x_o,
  input logic signed [POS_W-1:0] center_y_o,
  input logic signed [POS_W-1:0] center_z_o,
  input logic                    no_mass_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(center_x_o)
      && $stable(center_y_o) && $stable(center_z_o) && $stable(no_mass_o))
    else $error("result word dropped or changed while stalled");

  // an empty set reports a zero center
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_mass_o |-> center_x_o == '0 && center_y_o == '0
      && center_z_o == '0)
    else $error("no_mass result with nonzero center");

  // the block is not ready in the cycle after it takes the last atom of a set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && is_last_i |=> !in_ready_o)
    else $error("ready right after last atom");

  // a result never appears the cycle after an atom is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result raised too early after accept");

endmodule

bind masked_center_of_mass mcom_props u_mcom_props (.*);

/* tb/sv/mcom_checker.sv */
// Checker for the masked center-of-mass block: follows the atom and result
// channels, predicts the center of each atom set and compares result words.
// Depends on mcom_pkg for field and accumulator widths.
module mcom_checker
  import mcom_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    in_qm_i,
  input  logic                    in_boundary_i,
  input  logic [MASS_IN_W-1:0]    mass_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic                    is_last_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [POS_W-1:0] center_x_i,
  input  logic signed [POS_W-1:0] center_y_i,
  input  logic signed [POS_W-1:0] center_z_i,
  input  logic                    no_mass_i,
  output int                      err_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic                    no_mass;
  } center_t;

  // centers owed by the block, oldest first
  center_t           centers_due[$];
  logic [MASS_W-1:0] mass_sum;
  logic [MOM_W-1:0]  moment_x;
  logic [MOM_W-1:0]  moment_y;
  logic [MOM_W-1:0]  moment_z;
  int                errs;

  // mass * position, added into a wrapping moment sum
  function automatic logic [MOM_W-1:0] add_moment(input logic [MOM_W-1:0] acc,
                                                  input logic [MASS_IN_W-1:0] m,
                                                  input logic signed [POS_W-1:0] p);
    logic signed [63:0] prod;
    prod = longint'(m) * longint'(p);
    return acc + prod[MOM_W-1:0];
  endfunction

  // moment / mass, truncated toward zero, clamped to the coordinate range
  function automatic logic signed [POS_W-1:0] mean_coord(input logic [MOM_W-1:0] mom,
                                                         input logic [MASS_W-1:0] total);
    longint num;
    longint den;
    longint q;
    num = longint'($signed(mom));
    den = longint'({1'b0, total});
    q   = num / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[POS_W-1:0];
  endfunction

  task automatic check_field(input string field, input logic signed [POS_W-1:0] want,
                             input logic signed [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    center_t due;
    if (!rst_ni) begin
      mass_sum = '0;
      moment_x = '0;
      moment_y = '0;
      moment_z = '0;
      errs     = 0;
      centers_due.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      // atom word: accumulate if selected, close the set on the last one
      if (in_valid_i && in_ready_i) begin
        if (in_qm_i || in_boundary_i) begin
          mass_sum = mass_sum + MASS_W'(mass_i);
          moment_x = add_moment(moment_x, mass_i, pos_x_i);
          moment_y = add_moment(moment_y, mass_i, pos_y_i);
          moment_z = add_moment(moment_z, mass_i, pos_z_i);
        end
        if (is_last_i) begin
          due = '0;
          if (mass_sum == '0) begin
            due.no_mass = 1'b1;
          end else begin
            due.cx = mean_coord(moment_x, mass_sum);
            due.cy = mean_coord(moment_y, mass_sum);
            due.cz = mean_coord(moment_z, mass_sum);
          end
          centers_due = {centers_due, due};
          mass_sum = '0;
          moment_x = '0;
          moment_y = '0;
          moment_z = '0;
        end
      end
      // result word: compare with the oldest owed center
      if (out_valid_i && out_ready_i) begin
        if (centers_due.size() == 0) begin
          $error("result word with no set pending: x %0d y %0d z %0d no_mass %0b",
                 center_x_i, center_y_i, center_z_i, no_mass_i);
          errs++;
        end else begin
          due = centers_due.pop_front();
          check_field("center_x", due.cx, center_x_i);
          check_field("center_y", due.cy, center_y_i);
          check_field("center_z", due.cz, center_z_i);
          check_field("no_mass", POS_W'(due.no_mass), POS_W'(no_mass_i));
        end
      end
      err_count_o <= errs;
      pending_o   <= centers_due.size();
    end
  end

endmodule

/* tb/sv/tb_masked_center_of_mass.sv */
// Top of the masked center-of-mass testbench: clock, reset, atom stimulus,
// result back-pressure and the verdict. Depends on mcom_pkg, the block
// masked_center_of_mass and the checker mcom_checker.
module tb_masked_center_of_mass
  import mcom_pkg::*;
();

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ATOMS = 700;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [MASS_IN_W-1:0]    MASS_MAX = '1;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_qm;
  logic                    in_boundary;
  logic [MASS_IN_W-1:0]    mass;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    is_last;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [POS_W-1:0] center_x;
  logic signed [POS_W-1:0] center_y;
  logic signed [POS_W-1:0] center_z;
  logic                    no_mass;
  int                      err_count;
  int                      pending;
  int                      cycles;
  bit                      calm;  // no gaps and no stalls while set

  masked_center_of_mass dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_qm_i      (in_qm),
    .in_boundary_i(in_boundary),
    .mass_i       (mass),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .is_last_i    (is_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .center_x_o   (center_x),
    .center_y_o   (center_y),
    .center_z_o   (center_z),
    .no_mass_o    (no_mass)
  );

  mcom_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_qm_i      (in_qm),
    .in_boundary_i(in_boundary),
    .mass_i       (mass),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .is_last_i    (is_last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .center_x_i   (center_x),
    .center_y_i   (center_y),
    .center_z_i   (center_z),
    .no_mass_i    (no_mass),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall before taking each result word
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // one atom word: optional gap, then hold until accepted
  task automatic send_atom(input logic qm, input logic bnd, input logic [MASS_IN_W-1:0] m,
                           input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                           input logic signed [POS_W-1:0] z, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_qm       <= qm;
    in_boundary <= bnd;
    mass        <= m;
    pos_x       <= x;
    pos_y       <= y;
    pos_z       <= z;
    is_last     <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off the atom side until every owed center has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [MASS_IN_W-1:0] rand_mass();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return MASS_MAX;
      default: return MASS_IN_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0:       return POS_MIN;
      1:       return POS_MAX;
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4:    return $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
      default: return $urandom;
    endcase
  endfunction

  // one atom set of random length; returns how many atoms were sent
  task automatic send_random_set(output int count);
    int   len;
    int   kind;
    int   sel_pct;
    logic sel;
    logic [1:0] flags;
    logic [MASS_IN_W-1:0] m;
    kind     = $urandom_range(0, 9);
    len      = (kind == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    sel_pct  = (kind == 1) ? 0 : 80;
    count    = len;
    for (int i = 0; i < len; i++) begin
      sel   = $urandom_range(0, 99) < sel_pct;
      flags = sel ? 2'($urandom_range(1, 3)) : 2'b00;
      m     = (kind == 2) ? '0 : rand_mass();
      send_atom(flags[0], flags[1], m, rand_pos(), rand_pos(), rand_pos(), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int added;
    int sent;
    calm        = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_qm       <= 1'b0;
    in_boundary <= 1'b0;
    mass        <= '0;
    pos_x       <= '0;
    pos_y       <= '0;
    pos_z       <= '0;
    is_last     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty sets: nothing selected, and selected but weightless
    send_atom(1'b0, 1'b0, MASS_MAX, POS_MAX, POS_MIN, '1, 1'b1);
    send_atom(1'b1, 1'b1, '0, POS_MAX, POS_MAX, POS_MAX, 1'b1);
    // single atoms: center is the atom itself, each flag alone and both
    send_atom(1'b1, 1'b0, MASS_MAX, POS_MAX, POS_MIN, '0, 1'b1);
    send_atom(1'b0, 1'b1, 16'd1, '1, 32'sd1, POS_MIN, 1'b1);
    send_atom(1'b1, 1'b1, MASS_MAX, POS_MIN, POS_MAX, '1, 1'b1);
    // truncation toward zero, unselected heavy last atom
    send_atom(1'b1, 1'b0, 16'd2, -32'sd1, 32'sd1, -32'sd3, 1'b0);
    send_atom(1'b0, 1'b1, 16'd1, '0, '0, '0, 1'b0);
    send_atom(1'b0, 1'b0, MASS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b1);
    // heavy atoms at opposite extremes
    send_atom(1'b1, 1'b0, MASS_MAX, POS_MAX, POS_MAX, POS_MIN, 1'b0);
    send_atom(1'b0, 1'b1, MASS_MAX, POS_MIN, POS_MIN, POS_MAX, 1'b0);
    send_atom(1'b1, 1'b1, 16'd1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd7, 1'b1);
    // weightless atom followed by a light one
    send_atom(1'b1, 1'b0, '0, POS_MAX, POS_MIN, POS_MAX, 1'b0);
    send_atom(1'b1, 1'b0, 16'd3, -32'sd7, 32'sd7, 32'sd100, 1'b1);
    wait_drained();

    // random sets, with calm stretches and occasional full drains
    sent = 0;
    while (sent < RANDOM_ATOMS) begin
      if ($urandom_range(0, 5) == 0) calm = !calm;
      send_random_set(added);
      sent += added;
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
design/mcom_pkg.sv
design/masked_center_of_mass.sv
design/mcom_checker.sv
tb/sv/mcom_checker.sv
tb/sv/tb_masked_center_of_mass.sv
